// ----- rtl/pqm_pkg.sv -----
// Shared types and codes for the process queue manager.
package pqm_pkg;

  // Requested action on the selected queue
  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_POLL   = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_READ   = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_CLEAR  = 3'd5
  } pqm_action_t;

  // Result status reported with every transfer
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } pqm_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_INS,
    ST_PUT,
    ST_REM,
    ST_READ,
    ST_FIND,
    ST_DONE
  } pqm_state_t;

  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned FPOS_W   = 5;
  localparam int unsigned LEN_W    = 6;

endpackage

// ----- rtl/pqm_mem.sv -----
// Queue entry memory: one write port, one read port with registered read data.
module pqm_mem #(
  parameter int unsigned AW = 6,
  parameter int unsigned DW = 80
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/process_queue_manager.sv -----
// Process queue manager top level: sequencer walking one shared queue memory.
// Flow: a taken item is decoded in ST_START, then walks the queue entries read from memory
// (ST_INS and, for an insert at the head, ST_PUT; ST_REM, ST_READ or ST_FIND) to ST_DONE.
// Throughput: one item at a time; the next is taken the cycle after the result is
// registered, and ST_DONE holds the result while the output register is stalled.
// Reset (rst_n low, synchronous) empties both queues and drops any pending result.
module process_queue_manager #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned NAME_BITS   = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_action,
  input  logic                        in_which_queue,
  input  logic [pqm_pkg::HANDLE_W-1:0] in_handle,
  input  logic [63:0]                 in_name_key,
  input  logic signed [pqm_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [pqm_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pqm_pkg::HANDLE_W-1:0] out_result_handle,
  output logic                        out_found,
  output logic [pqm_pkg::FPOS_W-1:0]  out_found_position,
  output logic [pqm_pkg::LEN_W-1:0]   out_queue_length,
  output logic [1:0]                  out_status
);

  import pqm_pkg::*;

  localparam int unsigned IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW   = IW + 1;
  localparam int unsigned DW   = PRIO_W + HANDLE_W + NAME_BITS;
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // Captured item
  pqm_state_t               state_r, state_nxt;
  pqm_action_t              op_r;
  logic                     blk_r;
  logic [HANDLE_W-1:0]      hnd_r;
  logic [NAME_BITS-1:0]     key_r;
  logic signed [PRIO_W-1:0] prio_r;
  logic [POS_W-1:0]         pos_r;

  // Walk control and queue lengths
  logic [IW-1:0]            rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]            base_r, base_nxt;
  logic [CW-1:0]            rcnt_r, rcnt_nxt;
  logic [CW-1:0]            bcnt_r, bcnt_nxt;

  // Working result
  logic [HANDLE_W-1:0]      res_handle_r, res_handle_nxt;
  logic                     res_found_r, res_found_nxt;
  logic [FPOS_W-1:0]        res_pos_r, res_pos_nxt;
  pqm_status_t              res_status_r, res_status_nxt;

  // Output register
  logic                     out_valid_r;
  logic [HANDLE_W-1:0]      out_handle_r;
  logic                     out_found_r;
  logic [FPOS_W-1:0]        out_pos_r;
  logic [LEN_W-1:0]         out_len_r;
  pqm_status_t              out_status_r;

  // Memory port signals
  logic                     mem_we;
  logic [IW-1:0]            mem_widx;
  logic [DW-1:0]            mem_wdata;
  logic [DW-1:0]            rdata;
  logic [DW-1:0]            new_entry;

  // Shared compare unit and derived conditions
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            cnt_new;
  logic                     cnt_set;
  logic [IW-1:0]            last_idx;
  logic                     cnt_zero, cnt_full, pos_oor, is_last, prio_less, name_hit;
  logic                     take, out_free;
  logic [HANDLE_W-1:0]      rd_handle;
  logic [NAME_BITS-1:0]     rd_name;
  logic signed [PRIO_W-1:0] rd_prio;

  assign in_stall  = (state_r != ST_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign cnt       = blk_r ? bcnt_r : rcnt_r;
  assign last_idx  = IW'(cnt - CW'(1));
  assign cnt_zero  = (cnt == '0);
  assign cnt_full  = (cnt == CW'(QUEUE_DEPTH));
  assign pos_oor   = (CMPW'(pos_r) >= CMPW'(cnt));
  assign is_last   = (rd_idx_r == last_idx);

  assign rd_name   = rdata[NAME_BITS-1:0];
  assign rd_handle = rdata[NAME_BITS +: HANDLE_W];
  assign rd_prio   = $signed(rdata[NAME_BITS+HANDLE_W +: PRIO_W]);
  assign prio_less = (rd_prio < prio_r);
  assign name_hit  = (rd_name == key_r);
  assign new_entry = {prio_r, hnd_r, key_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) state_nxt = ST_START;
      end
      ST_START: begin
        case (op_r)
          ACT_INSERT: state_nxt = (cnt_full || blk_r || cnt_zero) ? ST_DONE : ST_INS;
          ACT_POLL:   state_nxt = cnt_zero ? ST_DONE : ST_REM;
          ACT_FIND:   state_nxt = cnt_zero ? ST_DONE : ST_FIND;
          ACT_READ:   state_nxt = pos_oor ? ST_DONE : ST_READ;
          ACT_REMOVE: state_nxt = pos_oor ? ST_DONE : ST_REM;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_INS: begin
        if (!prio_less) begin
          state_nxt = ST_DONE;
        end else if (rd_idx_r == '0) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT:  state_nxt = ST_DONE;
      ST_REM: begin
        if (is_last) state_nxt = ST_DONE;
      end
      ST_READ: state_nxt = ST_DONE;
      ST_FIND: begin
        if (name_hit || is_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: memory walk, result and length updates
  always_comb begin
    rd_idx_nxt     = rd_idx_r;
    base_nxt       = base_r;
    res_handle_nxt = res_handle_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_widx       = '0;
    mem_wdata      = new_entry;
    cnt_set        = 1'b0;
    cnt_new        = cnt;
    case (state_r)
      ST_START: begin
        res_handle_nxt = '0;
        res_found_nxt  = 1'b0;
        res_pos_nxt    = '0;
        res_status_nxt = STAT_OK;
        case (op_r)
          ACT_INSERT: begin
            if (cnt_full) begin
              res_status_nxt = STAT_FULL;
            end else if (blk_r || cnt_zero) begin
              // append at the tail
              mem_we   = 1'b1;
              mem_widx = IW'(cnt);
              cnt_set  = 1'b1;
              cnt_new  = cnt + CW'(1);
            end else begin
              rd_idx_nxt = last_idx;
            end
          end
          ACT_POLL: begin
            if (cnt_zero) begin
              res_status_nxt = STAT_EMPTY;
            end else begin
              rd_idx_nxt = '0;
              base_nxt   = '0;
            end
          end
          ACT_FIND: begin
            if (cnt_zero) begin
              res_status_nxt = STAT_EMPTY;
            end else begin
              rd_idx_nxt = '0;
            end
          end
          ACT_READ, ACT_REMOVE: begin
            if (pos_oor) begin
              res_status_nxt = STAT_RANGE;
            end else begin
              rd_idx_nxt = IW'(pos_r);
              base_nxt   = IW'(pos_r);
            end
          end
          ACT_CLEAR: begin
            cnt_set = 1'b1;
            cnt_new = '0;
          end
          default: begin
          end
        endcase
      end
      ST_INS: begin
        // walk from the tail, moving lower priorities up by one
        mem_we   = 1'b1;
        mem_widx = rd_idx_r + IW'(1);
        if (prio_less) begin
          mem_wdata = rdata;
          if (rd_idx_r != '0) rd_idx_nxt = rd_idx_r - IW'(1);
        end else begin
          cnt_set = 1'b1;
          cnt_new = cnt + CW'(1);
        end
      end
      ST_PUT: begin
        mem_we   = 1'b1;
        mem_widx = '0;
        cnt_set  = 1'b1;
        cnt_new  = cnt + CW'(1);
      end
      ST_REM: begin
        // capture the removed entry, then close the gap
        if (rd_idx_r == base_r) begin
          res_handle_nxt = rd_handle;
          res_found_nxt  = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_widx  = rd_idx_r - IW'(1);
          mem_wdata = rdata;
        end
        if (is_last) begin
          cnt_set = 1'b1;
          cnt_new = cnt - CW'(1);
        end else begin
          rd_idx_nxt = rd_idx_r + IW'(1);
        end
      end
      ST_READ: begin
        res_handle_nxt = rd_handle;
        res_found_nxt  = 1'b1;
      end
      ST_FIND: begin
        if (name_hit) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = FPOS_W'(rd_idx_r);
        end else if (is_last) begin
          res_status_nxt = STAT_EMPTY;
        end else begin
          rd_idx_nxt = rd_idx_r + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Route the length update to the selected queue
  always_comb begin
    rcnt_nxt = rcnt_r;
    bcnt_nxt = bcnt_r;
    if (cnt_set) begin
      if (blk_r) begin
        bcnt_nxt = cnt_new;
      end else begin
        rcnt_nxt = cnt_new;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rcnt_r  <= '0;
      bcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rcnt_r  <= rcnt_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

  // Capture the item and advance the walk
  always_ff @(posedge clk) begin
    if (take) begin
      op_r   <= pqm_action_t'(in_action);
      blk_r  <= in_which_queue;
      hnd_r  <= in_handle;
      key_r  <= in_name_key[NAME_BITS-1:0];
      prio_r <= in_priority_req;
      pos_r  <= in_position;
    end
    rd_idx_r     <= rd_idx_nxt;
    base_r       <= base_nxt;
    res_handle_r <= res_handle_nxt;
    res_found_r  <= res_found_nxt;
    res_pos_r    <= res_pos_nxt;
    res_status_r <= res_status_nxt;
  end

  // Output register: load on completion, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_handle_r <= res_handle_r;
      out_found_r  <= res_found_r;
      out_pos_r    <= res_pos_r;
      out_len_r    <= LEN_W'(cnt);
      out_status_r <= res_status_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_handle  = out_handle_r;
  assign out_found          = out_found_r;
  assign out_found_position = out_pos_r;
  assign out_queue_length   = out_len_r;
  assign out_status         = out_status_r;

  // Both queues share one memory, selected by the top address bit
  pqm_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({blk_r, mem_widx}),
    .wdata (mem_wdata),
    .raddr ({blk_r, rd_idx_nxt}),
    .rdata (rdata)
  );

  // Queue lengths never exceed the depth
  a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= CW'(QUEUE_DEPTH))
    else $error("ready queue length beyond depth");

  a_bcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= CW'(QUEUE_DEPTH))
    else $error("blocked queue length beyond depth");

  // An accepted item is decoded in the next cycle
  a_take_start: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> state_r == ST_START)
    else $error("accepted item not decoded");

  // Memory is written only while an item is being worked on
  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != ST_IDLE && state_r != ST_DONE))
    else $error("queue memory written while idle");

  // A result without a hit carries zero handle and position
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_handle_r == '0 && out_pos_r == '0))
    else $error("unused result fields not zero");

endmodule

// ----- bench/tb_process_queue_manager.sv -----
`timescale 1ns / 1ps
// Self-checking bench for process_queue_manager: model-based scoreboard, bursty driver, stalls.
module tb_process_queue_manager;
  import pqm_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned NAME_BITS   = 64;
  localparam logic [63:0] NAME_MASK   = {64{1'b1}} >> (64 - NAME_BITS);
  localparam logic        READY_Q     = 1'b0;
  localparam logic        BLOCKED_Q   = 1'b1;
  localparam int          RANDOM_ITEMS = 850;
  localparam int          IDLE_LIMIT  = 4000;

  typedef struct packed {
    pqm_action_t       action;
    logic              which;
    logic [7:0]        handle;
    logic [63:0]       name_key;
    logic [7:0]        prio;
    logic [5:0]        position;
  } proc_request_t;

  typedef struct packed {
    logic [7:0]        handle;
    logic              found;
    logic [4:0]        found_pos;
    logic [5:0]        length;
    pqm_status_t       status;
  } proc_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = ACT_INSERT;
  logic        in_which_queue = 1'b0;
  logic [7:0]  in_handle = 8'd0;
  logic [63:0] in_name_key = 64'd0;
  logic signed [7:0] in_priority_req = 8'sd0;
  logic [5:0]  in_position = 6'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_result_handle;
  logic        out_found;
  logic [4:0]  out_found_position;
  logic [5:0]  out_queue_length;
  logic [1:0]  out_status;

  // Scoreboard and traffic bookkeeping
  proc_request_t pending_items[$];
  proc_reply_t   expected_replies[$];
  proc_request_t next_req;
  int            queued_count = 0;
  int            accepted_count = 0;
  int            error_count = 0;
  int            idle_cycles = 0;
  bit            in_fire = 1'b0;
  bit            out_fire = 1'b0;
  int            burst_left = 8;
  int            gap_left = 0;
  int            stall_mode = 0;
  int            stall_span = 0;

  // Shadow copy of both queues
  logic [7:0]  model_handle [2][QUEUE_DEPTH];
  logic [63:0] model_name   [2][QUEUE_DEPTH];
  logic [7:0]  model_prio   [2][QUEUE_DEPTH];
  int          model_count  [2] = '{0, 0};

  process_queue_manager #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NAME_BITS  (NAME_BITS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_which_queue    (in_which_queue),
    .in_handle         (in_handle),
    .in_name_key       (in_name_key),
    .in_priority_req   (in_priority_req),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_handle (out_result_handle),
    .out_found         (out_found),
    .out_found_position(out_found_position),
    .out_queue_length  (out_queue_length),
    .out_status        (out_status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shift later entries down over the removed one
  function automatic void close_gap(int q, int pos);
    for (int i = pos; i + 1 < model_count[q]; i++) begin
      model_handle[q][i] = model_handle[q][i + 1];
      model_name[q][i]   = model_name[q][i + 1];
      model_prio[q][i]   = model_prio[q][i + 1];
    end
    model_count[q]--;
  endfunction

  // Apply one request to the shadow queues and work out its reply
  function automatic proc_reply_t predict_outcome(proc_request_t req);
    proc_reply_t rep;
    int          q;
    int          cnt;
    int          at;
    logic [63:0] key;
    rep.handle    = 8'd0;
    rep.found     = 1'b0;
    rep.found_pos = 5'd0;
    rep.status    = STAT_OK;
    q   = int'(req.which);
    cnt = model_count[q];
    key = req.name_key & NAME_MASK;
    case (req.action)
      ACT_INSERT: begin
        if (cnt >= QUEUE_DEPTH) begin
          rep.status = STAT_FULL;
        end else begin
          at = cnt;
          // Ready queue: go before the first strictly lower priority; blocked queue appends
          if (req.which == READY_Q) begin
            for (int i = 0; i < cnt; i++) begin
              if (at == cnt && $signed(model_prio[q][i]) < $signed(req.prio)) at = i;
            end
          end
          for (int i = cnt; i > at; i--) begin
            model_handle[q][i] = model_handle[q][i - 1];
            model_name[q][i]   = model_name[q][i - 1];
            model_prio[q][i]   = model_prio[q][i - 1];
          end
          model_handle[q][at] = req.handle;
          model_name[q][at]   = key;
          model_prio[q][at]   = req.prio;
          model_count[q]++;
        end
      end
      ACT_POLL: begin
        if (cnt == 0) begin
          rep.status = STAT_EMPTY;
        end else begin
          rep.handle = model_handle[q][0];
          rep.found  = 1'b1;
          close_gap(q, 0);
        end
      end
      ACT_FIND: begin
        rep.status = STAT_EMPTY;
        for (int i = 0; i < cnt; i++) begin
          if (!rep.found && model_name[q][i] == key) begin
            rep.found     = 1'b1;
            rep.found_pos = i[4:0];
            rep.status    = STAT_OK;
          end
        end
      end
      ACT_READ, ACT_REMOVE: begin
        if (int'(req.position) >= cnt) begin
          rep.status = STAT_RANGE;
        end else begin
          rep.handle = model_handle[q][req.position];
          rep.found  = 1'b1;
          if (req.action == ACT_REMOVE) close_gap(q, int'(req.position));
        end
      end
      ACT_CLEAR: model_count[q] = 0;
      default: ;
    endcase
    rep.length = model_count[q][5:0];
    return rep;
  endfunction

  task automatic push_request(input pqm_action_t act, input logic which, input logic [7:0] hnd,
                              input logic [63:0] key, input logic [7:0] prio,
                              input logic [5:0] pos);
    proc_request_t req;
    req.action   = act;
    req.which    = which;
    req.handle   = hnd;
    req.name_key = key;
    req.prio     = prio;
    req.position = pos;
    pending_items.push_back(req);
    queued_count++;
  endtask

  // Names come mostly from a small pool so that finds hit
  function automatic logic [63:0] pick_name();
    case ($urandom_range(0, 11))
      0: return "init";
      1: return "shell";
      2: return "kswapd";
      3: return "cron";
      4: return "sshd";
      5: return "getty";
      6: return "httpd";
      7: return "logger";
      8: return 64'd0;
      9: return {64{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Priorities mostly few distinct values so that ties occur
  function automatic logic [7:0] pick_prio();
    case ($urandom_range(0, 5))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'($urandom_range(0, 3));
      5: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_random(input bit filling, input logic fav_queue);
    int          r;
    pqm_action_t act;
    logic        which;
    logic [5:0]  pos;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 62)      act = ACT_INSERT;
      else if (r < 70) act = ACT_POLL;
      else if (r < 80) act = ACT_FIND;
      else if (r < 88) act = ACT_READ;
      else if (r < 99) act = ACT_REMOVE;
      else             act = ACT_CLEAR;
    end else begin
      if (r < 20)      act = ACT_INSERT;
      else if (r < 42) act = ACT_POLL;
      else if (r < 55) act = ACT_FIND;
      else if (r < 70) act = ACT_READ;
      else if (r < 98) act = ACT_REMOVE;
      else             act = ACT_CLEAR;
    end
    which = ($urandom_range(0, 9) < 7) ? fav_queue : ~fav_queue;
    pos = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 33));
    push_request(act, which, 8'($urandom_range(0, 255)), pick_name(), pick_prio(), pos);
  endtask

  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
      error_count++;
    end
  endtask

  // Drive requests at the falling edge, in bursts with gaps
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_req = pending_items.pop_front();
        in_action       <= next_req.action;
        in_which_queue  <= next_req.which;
        in_handle       <= next_req.handle;
        in_name_key     <= next_req.name_key;
        in_priority_req <= next_req.prio;
        in_position     <= next_req.position;
        in_valid        <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: windows of no, light or heavy back-pressure
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_span = $urandom_range(10, 150);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Predict on each accepted request, check each accepted reply
  always @(posedge clk) begin
    proc_request_t seen;
    proc_reply_t   want;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (in_fire) begin
      seen.action   = pqm_action_t'(in_action);
      seen.which    = in_which_queue;
      seen.handle   = in_handle;
      seen.name_key = in_name_key;
      seen.prio     = in_priority_req;
      seen.position = in_position;
      expected_replies.push_back(predict_outcome(seen));
      accepted_count++;
    end
    if (out_fire) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with nothing expected: handle %0h status %0d", $time,
                 out_result_handle, out_status);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("result_handle", 64'(want.handle), 64'(out_result_handle));
        check_field("found", 64'(want.found), 64'(out_found));
        check_field("found_position", 64'(want.found_pos), 64'(out_found_position));
        check_field("queue_length", 64'(want.length), 64'(out_queue_length));
        check_field("status", 64'(want.status), 64'(out_status));
      end
    end
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
  end

  // Watchdog on cycles with no transfer at all
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: watchdog expired", $time);
    $display("Some tests failed");
    $finish;
  end

  // Reset, directed requests, drain, then random segments
  initial begin
    int  seg_len;
    bit  filling;
    logic fav;
    int  random_left;

    push_request(ACT_POLL,   READY_Q,   8'h00, 64'd0, 8'h00, 6'd0);
    push_request(ACT_POLL,   BLOCKED_Q, 8'h00, 64'd0, 8'h00, 6'd0);
    push_request(ACT_FIND,   READY_Q,   8'h00, "init", 8'h00, 6'd0);
    push_request(ACT_READ,   READY_Q,   8'h00, 64'd0, 8'h00, 6'd0);
    push_request(ACT_REMOVE, BLOCKED_Q, 8'h00, 64'd0, 8'h00, 6'd63);
    push_request(ACT_INSERT, READY_Q,   8'h00, 64'd0, 8'h80, 6'd0);
    push_request(ACT_INSERT, READY_Q,   8'hFF, {64{1'b1}}, 8'h7F, 6'd63);
    push_request(ACT_INSERT, READY_Q,   8'h11, "shell", 8'h00, 6'd0);
    push_request(ACT_INSERT, READY_Q,   8'h22, "cron", 8'h00, 6'd0);
    push_request(ACT_INSERT, READY_Q,   8'h33, "sshd", 8'h7F, 6'd0);
    push_request(ACT_INSERT, BLOCKED_Q, 8'hAA, {64{1'b1}}, 8'h7F, 6'd0);
    push_request(ACT_INSERT, BLOCKED_Q, 8'h55, 64'd0, 8'h80, 6'd0);
    push_request(ACT_FIND,   READY_Q,   8'h00, "cron", 8'h00, 6'd0);
    push_request(ACT_FIND,   READY_Q,   8'h00, "missing", 8'h00, 6'd0);
    push_request(ACT_FIND,   BLOCKED_Q, 8'h00, {64{1'b1}}, 8'h00, 6'd0);
    push_request(ACT_READ,   READY_Q,   8'h00, 64'd0, 8'h00, 6'd4);
    push_request(ACT_READ,   READY_Q,   8'h00, 64'd0, 8'h00, 6'd5);
    push_request(ACT_READ,   READY_Q,   8'h00, 64'd0, 8'h00, 6'd63);
    push_request(ACT_REMOVE, READY_Q,   8'h00, 64'd0, 8'h00, 6'd2);
    push_request(ACT_POLL,   READY_Q,   8'h00, 64'd0, 8'h00, 6'd0);
    push_request(ACT_POLL,   BLOCKED_Q, 8'h00, 64'd0, 8'h00, 6'd0);
    push_request(ACT_CLEAR,  READY_Q,   8'h00, 64'd0, 8'h00, 6'd0);
    push_request(ACT_READ,   READY_Q,   8'h00, 64'd0, 8'h00, 6'd0);
    push_request(ACT_CLEAR,  BLOCKED_Q, 8'h00, 64'd0, 8'h00, 6'd0);
    push_request(ACT_INSERT, READY_Q,   8'h5A, "getty", 8'h01, 6'd0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Hold off new requests until every directed reply has come back
    while (accepted_count != queued_count || expected_replies.size() != 0) @(negedge clk);

    // Alternate filling and draining segments, each favouring one queue
    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      seg_len = $urandom_range(40, 150);
      filling = 1'($urandom_range(0, 1));
      fav     = 1'($urandom_range(0, 1));
      for (int i = 0; i < seg_len && random_left > 0; i++) begin
        push_random(filling, fav);
        random_left--;
      end
    end

    while (accepted_count != queued_count || expected_replies.size() != 0) @(negedge clk);
    repeat (QUEUE_DEPTH + 8) @(posedge clk);

    if (expected_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, expected_replies.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pqm_pkg.sv
rtl/pqm_mem.sv
rtl/process_queue_manager.sv
bench/tb_process_queue_manager.sv
